// ===== sv/modbus_request_frame_decoder_macros.svh =====
// Assertion macros for the Modbus request frame decoder checker.
// Expects signals named clk and rst_n in the scope where a macro is used.
`ifndef MODBUS_REQUEST_FRAME_DECODER_MACROS_SVH
`define MODBUS_REQUEST_FRAME_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define MRFD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define MRFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/mrfd_pkg.sv =====
// Shared types, constants and functions of the Modbus request frame decoder.
// Used by the front, queue, back, top level and checker; depends on nothing.
`default_nettype none

package mrfd_pkg;

  localparam int FRAME_BYTES = 8;
  localparam int FIDX_W      = $clog2(FRAME_BYTES);
  localparam int FILL_W      = $clog2(FRAME_BYTES + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int CRC_BYTES   = 6;
  localparam int CIDX_W      = $clog2(CRC_BYTES);
  localparam int FIXED_KINDS = 29;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] STATION_RESET  = 8'd1;
  localparam logic [7:0] READ_OP_RESET  = 8'd3;
  localparam logic [7:0] WRITE_OP_RESET = 8'd6;

  // Register indexes on the configuration port (byte address / 4).
  localparam logic [1:0] REG_STATION  = 2'd0;
  localparam logic [1:0] REG_READ_OP  = 2'd1;
  localparam logic [1:0] REG_WRITE_OP = 2'd2;

  // Banked request kinds.
  localparam logic [5:0] KIND_CELL_VOLT = 6'd29;
  localparam logic [5:0] KIND_TEMP      = 6'd30;
  localparam logic [5:0] KIND_CELL_PAIR = 6'd31;
  localparam logic [5:0] KIND_TEMP_PAIR = 6'd32;

  localparam logic [15:0] FIXED_ADDR [FIXED_KINDS] = '{
    16'h0001, 16'h0002, 16'h0003, 16'h0005, 16'h0010, 16'h0025,
    16'h0030, 16'h0031, 16'h0032, 16'h0033, 16'h0034,
    16'h0040, 16'h0050,
    16'h0060, 16'h0061, 16'h0062, 16'h0063, 16'h0064,
    16'h0065, 16'h0066, 16'h0067, 16'h0068, 16'h0069,
    16'h0070, 16'h0071, 16'h0072, 16'h0073, 16'h0074, 16'h0075
  };

  typedef enum logic [2:0] {
    ST_READ        = 3'd0,
    ST_WRITE       = 3'd1,
    ST_CRC_ERR     = 3'd2,
    ST_UNKNOWN_CMD = 3'd3,
    ST_BAD_ADDR    = 3'd4
  } status_e_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CRC,
    BK_DONE
  } back_state_t;

  typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       line_idle;
  } in_item_t;

  typedef struct packed {
    status_e_t   status;
    logic [5:0]  request_kind;
    logic [8:0]  item_index;
    logic [15:0] data_address;
    logic [15:0] data_length;
  } out_item_t;

  typedef struct packed {
    logic [7:0] station_address;
    logic [7:0] read_opcode;
    logic [7:0] write_opcode;
  } cfg_t;

  // A complete frame handed from the front to the queue, or the queue head.
  typedef struct packed {
    logic   valid;
    frame_t frame;
  } frame_msg_t;

  typedef struct packed {
    logic       hit;
    logic [5:0] kind;
    logic [8:0] item;
  } addr_dec_t;

  // One byte of the reflected CRC-16, eight shift steps.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else      c = c >> 1;
    end
    return c;
  endfunction

  function automatic addr_dec_t decode_address(input logic [15:0] addr);
    addr_dec_t  d;
    logic [7:0] hi;
    logic [8:0] lo9;
    logic [8:0] h9;
    logic [8:0] hi20;
    logic [8:0] hi10;
    d    = '0;
    hi   = addr[15:8];
    lo9  = {1'b0, addr[7:0]};
    h9   = {5'b0, hi[3:0]};
    hi20 = (h9 << 4) + (h9 << 2);
    hi10 = (h9 << 3) + (h9 << 1);
    // Walk downward so the lowest matching index wins.
    for (int k = FIXED_KINDS - 1; k >= 0; k--) begin
      if (addr == FIXED_ADDR[k]) begin
        d.hit = 1'b1;
        d.kind = 6'(k);
      end
    end
    if (!d.hit && hi < 8'd16) begin
      if (lo9 >= 9'h011 && lo9 <= 9'h024) begin
        d.hit = 1'b1;
        d.kind = KIND_CELL_VOLT;
        d.item = hi20 + lo9 - 9'h010;
      end else if (lo9 >= 9'h026 && lo9 <= 9'h02F) begin
        d.hit = 1'b1;
        d.kind = KIND_TEMP;
        d.item = hi10 + lo9 - 9'h025;
      end else if (lo9 >= 9'h041 && lo9 <= 9'h04A) begin
        d.hit = 1'b1;
        d.kind = KIND_CELL_PAIR;
        d.item = hi20 + (lo9 << 1) - 9'h081;
      end else if (lo9 >= 9'h051 && lo9 <= 9'h055) begin
        d.hit = 1'b1;
        d.kind = KIND_TEMP_PAIR;
        d.item = hi10 + (lo9 << 1) - 9'h0A1;
      end
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== sv/mrfd_front.sv =====
// Front part: collects received bytes into the frame window and hands
// complete frames to the queue. Depends on mrfd_pkg.
`default_nettype none

module mrfd_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire mrfd_pkg::cfg_t     cfg,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire mrfd_pkg::in_item_t in_payload,
  input  wire logic               q_full,
  output mrfd_pkg::frame_msg_t    push
);

  mrfd_pkg::frame_t               win_r, win_nxt, win_s;
  logic [mrfd_pkg::FILL_W-1:0]    fill_r, fill_nxt, fill_s;
  logic [mrfd_pkg::FIDX_W-1:0]    sh;
  logic                           found;
  logic                           accept;
  logic                           take;
  logic                           complete;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    found = 1'b0;
    sh    = '0;
    // Find the first station byte behind position 0 of a full window.
    for (int i = mrfd_pkg::FRAME_BYTES - 1; i >= 1; i--) begin
      if (win_r[i] == cfg.station_address) begin
        found = 1'b1;
        sh    = mrfd_pkg::FIDX_W'(i);
      end
    end

    win_s  = win_r;
    fill_s = fill_r;
    if (fill_r == mrfd_pkg::FILL_W'(mrfd_pkg::FRAME_BYTES)) begin
      if (found) begin
        win_s  = win_r >> {sh, 3'b000};
        fill_s = mrfd_pkg::FILL_W'(mrfd_pkg::FRAME_BYTES) - {1'b0, sh};
      end else begin
        fill_s = '0;
      end
    end

    take = !(fill_s == '0 && in_payload.rx_byte != cfg.station_address);
    complete = take && in_payload.line_idle &&
               fill_s == mrfd_pkg::FILL_W'(mrfd_pkg::FRAME_BYTES - 1);

    win_nxt  = win_r;
    fill_nxt = fill_r;
    if (accept) begin
      win_nxt  = win_s;
      fill_nxt = fill_s;
      if (take) begin
        win_nxt[fill_s[mrfd_pkg::FIDX_W-1:0]] = in_payload.rx_byte;
        fill_nxt = complete ? '0 : fill_s + 1'b1;
      end
    end

    push.valid = accept && complete;
    push.frame = win_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

endmodule

`default_nettype wire

// ===== sv/mrfd_queue.sv =====
// Short frame queue between the front and the back part.
// Depends on mrfd_pkg for the frame message type.
`default_nettype none

module mrfd_queue #(
  parameter int DEPTH = mrfd_pkg::QUEUE_DEPTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire mrfd_pkg::frame_msg_t push,
  input  wire logic                 pop,
  output mrfd_pkg::frame_msg_t      head,
  output logic                      full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mrfd_pkg::frame_t     mem_r [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 do_push;
  logic                 do_pop;

  assign full       = (cnt_r == CNT_W'(DEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.frame = mem_r[rd_ptr_r];

  assign do_push = push.valid && !full;
  assign do_pop  = pop && head.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.frame;
    end
  end

endmodule

`default_nettype wire

// ===== sv/mrfd_back.sv =====
// Back part: runs the CRC one byte per cycle over the queue head, classifies
// the command, decodes the address and holds the result. Depends on mrfd_pkg.
`default_nettype none

module mrfd_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire mrfd_pkg::cfg_t       cfg,
  input  wire mrfd_pkg::frame_msg_t head,
  output logic                      pop,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output mrfd_pkg::out_item_t       out_payload
);

  mrfd_pkg::back_state_t        state_r, state_nxt;
  logic [15:0]                  crc_r, crc_nxt;
  logic [mrfd_pkg::CIDX_W-1:0]  idx_r, idx_nxt;
  logic                         out_valid_r, out_valid_nxt;
  mrfd_pkg::out_item_t          out_r, out_nxt;
  mrfd_pkg::out_item_t          res;
  mrfd_pkg::addr_dec_t          dec;
  mrfd_pkg::frame_t             fr;

  assign fr          = head.frame;
  assign out_valid   = out_valid_r;
  assign out_payload = out_r;

  // Result of the frame at the queue head, valid once the CRC has run.
  always_comb begin
    dec = mrfd_pkg::decode_address({fr[2], fr[3]});
    res = '{status: mrfd_pkg::ST_READ, request_kind: '0, item_index: '0,
            data_address: {fr[2], fr[3]}, data_length: {fr[4], fr[5]}};
    if (crc_r != {fr[7], fr[6]}) begin
      res.status = mrfd_pkg::ST_CRC_ERR;
    end else if (fr[1] == cfg.read_opcode) begin
      if (dec.hit) begin
        res.request_kind = dec.kind;
        res.item_index   = dec.item;
      end else begin
        res.status = mrfd_pkg::ST_BAD_ADDR;
      end
    end else if (fr[1] == cfg.write_opcode) begin
      res.status = mrfd_pkg::ST_WRITE;
    end else begin
      res.status = mrfd_pkg::ST_UNKNOWN_CMD;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    crc_nxt       = crc_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    pop           = 1'b0;
    unique case (state_r)
      mrfd_pkg::BK_IDLE: begin
        if (head.valid) begin
          crc_nxt   = mrfd_pkg::CRC_INIT;
          idx_nxt   = '0;
          state_nxt = mrfd_pkg::BK_CRC;
        end
      end
      mrfd_pkg::BK_CRC: begin
        crc_nxt = mrfd_pkg::crc_byte(crc_r, fr[idx_r]);
        idx_nxt = idx_r + 1'b1;
        if (idx_r == mrfd_pkg::CIDX_W'(mrfd_pkg::CRC_BYTES - 1)) begin
          state_nxt = mrfd_pkg::BK_DONE;
        end
      end
      mrfd_pkg::BK_DONE: begin
        // Wait here while an earlier result is still held by the receiver.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_nxt       = res;
          pop           = 1'b1;
          state_nxt     = mrfd_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = mrfd_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mrfd_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    crc_r <= crc_nxt;
    idx_r <= idx_nxt;
    out_r <= out_nxt;
  end

endmodule

`default_nettype wire

// ===== sv/modbus_request_frame_decoder.sv =====
// Top level of the Modbus request frame decoder: configuration registers,
// front, frame queue and back. Depends on mrfd_pkg and the mrfd_* modules.
//
// Usage: received bytes enter on the in_ channel (rx_byte plus a line_idle
// flag), one request per cycle while the frame queue has room. Bytes build
// an 8-byte window that opens on the station address; when the byte that
// fills it is marked line_idle, the frame moves into a two-entry queue.
// The back part takes the queue head, runs the CRC one byte per cycle over
// six bytes, then decodes, one frame at a time, and registers the result on
// out_ when the output is free. Frames that are not complete produce no
// result. in_stall rises only while the queue is full. When the receiver
// stalls, the result holds in the output register; the back part then
// waits with the next finished frame, and the front keeps taking bytes
// until the queue fills. Configuration uses an APB-style port, registers
// at byte addresses 0, 4 and 8; write only while no frame is in flight.
// Reset clears the window fill count, the queue and the output valid and
// loads the register defaults (station 1, read 3, write 6).
`default_nettype none

module modbus_request_frame_decoder #(
  parameter int QUEUE_DEPTH = mrfd_pkg::QUEUE_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire mrfd_pkg::in_item_t  in_payload,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output mrfd_pkg::out_item_t      out_payload,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [3:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  mrfd_pkg::cfg_t        cfg_r, cfg_nxt;
  mrfd_pkg::frame_msg_t  push;
  mrfd_pkg::frame_msg_t  head;
  logic                  q_full;
  logic                  pop;
  logic                  wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (paddr[3:2])
        mrfd_pkg::REG_STATION:  cfg_nxt.station_address = pwdata[7:0];
        mrfd_pkg::REG_READ_OP:  cfg_nxt.read_opcode     = pwdata[7:0];
        mrfd_pkg::REG_WRITE_OP: cfg_nxt.write_opcode    = pwdata[7:0];
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      mrfd_pkg::REG_STATION:  prdata = {24'h0, cfg_r.station_address};
      mrfd_pkg::REG_READ_OP:  prdata = {24'h0, cfg_r.read_opcode};
      mrfd_pkg::REG_WRITE_OP: prdata = {24'h0, cfg_r.write_opcode};
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.station_address <= mrfd_pkg::STATION_RESET;
      cfg_r.read_opcode     <= mrfd_pkg::READ_OP_RESET;
      cfg_r.write_opcode    <= mrfd_pkg::WRITE_OP_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  mrfd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_payload (in_payload),
    .q_full     (q_full),
    .push       (push)
  );

  mrfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .full  (q_full)
  );

  mrfd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_payload (out_payload)
  );

endmodule

`default_nettype wire

// ===== sv/mrfd_checker.sv =====
// Port-level checker for the Modbus request frame decoder, bound to the top.
// Depends on mrfd_pkg and the macros header.
`default_nettype none

`include "modbus_request_frame_decoder_macros.svh"

module mrfd_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire mrfd_pkg::out_item_t out_payload
);

  logic out_held;
  logic is_read;
  logic is_other;
  logic status_ok;
  logic non_read_clear;
  logic read_item_ok;

  assign out_held       = out_valid && out_stall;
  assign is_read        = out_valid && out_payload.status == mrfd_pkg::ST_READ;
  assign is_other       = out_valid && out_payload.status != mrfd_pkg::ST_READ;
  assign status_ok      = out_payload.status <= mrfd_pkg::ST_BAD_ADDR;
  assign non_read_clear = out_payload.request_kind == '0 && out_payload.item_index == '0;
  // Banked kinds always carry a nonzero item number, fixed kinds carry zero.
  assign read_item_ok   = out_payload.request_kind <= mrfd_pkg::KIND_TEMP_PAIR &&
                          ((out_payload.item_index == '0) ==
                           (out_payload.request_kind < mrfd_pkg::KIND_CELL_VOLT));

  `MRFD_ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(out_payload), "held result changed")
  `MRFD_ASSERT_IMPL(a_status_range, out_valid, status_ok, "status code out of range")
  `MRFD_ASSERT_IMPL(a_non_read_zero, is_other, non_read_clear, "non-read result carries a kind")
  `MRFD_ASSERT_IMPL(a_read_item, is_read, read_item_ok, "item number does not match request kind")

endmodule

bind modbus_request_frame_decoder mrfd_checker u_mrfd_checker (.*);

`default_nettype wire

// ===== tb/modbus_request_frame_decoder_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for modbus_request_frame_decoder: directed frames, then random
// byte streams under several register settings, checked against a built-in predictor.
// Depends on mrfd_pkg for the payload types, the status codes and the register indexes.

module modbus_request_frame_decoder_test;

  localparam int HALF_PERIOD = 5;
  localparam int RESET_CYCLES = 7;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int TAIL_CYCLES = 40;
  localparam int PHASES = 8;
  localparam int PHASE_BYTES = 215;
  localparam int WINDOW_BYTES = 8;
  localparam int CRC_SPAN = 6;

  localparam logic [15:0] CRC_SEED = 16'hFFFF;
  localparam logic [15:0] CRC_POLY_REFLECTED = 16'hA001;

  localparam logic [7:0] DEF_STATION = 8'h01;
  localparam logic [7:0] DEF_READ_OP = 8'h03;
  localparam logic [7:0] DEF_WRITE_OP = 8'h06;
  localparam logic [7:0] CMD_UNLISTED = 8'hFF;

  localparam logic [5:0] K_NONE = 6'd0;
  localparam logic [5:0] K_FIRST_FIXED = 6'd0;
  localparam logic [5:0] K_LAST_FIXED = 6'd28;
  localparam logic [5:0] K_CELL_VOLT = 6'd29;
  localparam logic [5:0] K_TEMP = 6'd30;
  localparam logic [5:0] K_CELL_PAIR = 6'd31;
  localparam logic [5:0] K_TEMP_PAIR = 6'd32;

  typedef struct packed {
    logic                 lead_on;
    logic [7:0]           lead;
    logic [7:0]           cmd;
    logic [15:0]          addr;
    logic [15:0]          len;
    logic                 bad_crc;
    logic                 idle_end;
    logic                 typed;
    mrfd_pkg::status_e_t  want_status;
    logic [5:0]           want_kind;
    logic [8:0]           want_item;
  } frame_row_t;

  localparam int SCRIPT_ROWS = 18;
  localparam frame_row_t SCRIPT [SCRIPT_ROWS] = '{
    '{1'b0, 8'h00, DEF_READ_OP, 16'h0001, 16'h0000, 1'b0, 1'b1, 1'b1,
      mrfd_pkg::ST_READ, K_FIRST_FIXED, 9'd0},
    '{1'b0, 8'h00, DEF_READ_OP, 16'h0075, 16'hFFFF, 1'b0, 1'b1, 1'b1,
      mrfd_pkg::ST_READ, K_LAST_FIXED, 9'd0},
    '{1'b0, 8'h00, DEF_READ_OP, 16'h0011, 16'h0001, 1'b0, 1'b1, 1'b1,
      mrfd_pkg::ST_READ, K_CELL_VOLT, 9'd1},
    '{1'b0, 8'h00, DEF_READ_OP, 16'h0F24, 16'h0002, 1'b0, 1'b1, 1'b1,
      mrfd_pkg::ST_READ, K_CELL_VOLT, 9'd320},
    '{1'b0, 8'h00, DEF_READ_OP, 16'h0026, 16'h0001, 1'b0, 1'b1, 1'b1,
      mrfd_pkg::ST_READ, K_TEMP, 9'd1},
    '{1'b0, 8'h00, DEF_READ_OP, 16'h0F2F, 16'h0001, 1'b0, 1'b1, 1'b1,
      mrfd_pkg::ST_READ, K_TEMP, 9'd160},
    '{1'b0, 8'h00, DEF_READ_OP, 16'h0041, 16'h0001, 1'b0, 1'b1, 1'b1,
      mrfd_pkg::ST_READ, K_CELL_PAIR, 9'd1},
    '{1'b0, 8'h00, DEF_READ_OP, 16'h0F4A, 16'h0001, 1'b0, 1'b1, 1'b1,
      mrfd_pkg::ST_READ, K_CELL_PAIR, 9'd319},
    '{1'b0, 8'h00, DEF_READ_OP, 16'h0051, 16'h0001, 1'b0, 1'b1, 1'b1,
      mrfd_pkg::ST_READ, K_TEMP_PAIR, 9'd1},
    '{1'b0, 8'h00, DEF_READ_OP, 16'h0F55, 16'h0001, 1'b0, 1'b1, 1'b1,
      mrfd_pkg::ST_READ, K_TEMP_PAIR, 9'd159},
    '{1'b0, 8'h00, DEF_WRITE_OP, 16'h1234, 16'h5678, 1'b0, 1'b1, 1'b1,
      mrfd_pkg::ST_WRITE, K_NONE, 9'd0},
    '{1'b0, 8'h00, DEF_READ_OP, 16'h0001, 16'h0000, 1'b1, 1'b1, 1'b1,
      mrfd_pkg::ST_CRC_ERR, K_NONE, 9'd0},
    '{1'b0, 8'h00, CMD_UNLISTED, 16'h0001, 16'h0000, 1'b0, 1'b1, 1'b1,
      mrfd_pkg::ST_UNKNOWN_CMD, K_NONE, 9'd0},
    '{1'b0, 8'h00, DEF_READ_OP, 16'hFFFF, 16'h0000, 1'b0, 1'b1, 1'b1,
      mrfd_pkg::ST_BAD_ADDR, K_NONE, 9'd0},
    '{1'b0, 8'h00, DEF_READ_OP, 16'h1011, 16'h0000, 1'b0, 1'b1, 1'b1,
      mrfd_pkg::ST_BAD_ADDR, K_NONE, 9'd0},
    // Stray byte ahead of a frame, then a frame left unfinished and a frame that slides it.
    '{1'b1, 8'hFF, DEF_READ_OP, 16'h0025, 16'h0003, 1'b0, 1'b1, 1'b0,
      mrfd_pkg::ST_READ, K_NONE, 9'd0},
    '{1'b0, 8'h00, DEF_READ_OP, 16'h0005, 16'h0101, 1'b0, 1'b0, 1'b0,
      mrfd_pkg::ST_READ, K_NONE, 9'd0},
    '{1'b0, 8'h00, DEF_WRITE_OP, 16'h0000, 16'h0000, 1'b0, 1'b1, 1'b0,
      mrfd_pkg::ST_READ, K_NONE, 9'd0}
  };

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  mrfd_pkg::in_item_t   in_payload = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  mrfd_pkg::out_item_t  out_payload;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [3:0]           paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  modbus_request_frame_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_payload (in_payload),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_payload(out_payload),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #HALF_PERIOD clk = ~clk;

  // Predictor state: the frame window and its own copy of the registers.
  mrfd_pkg::frame_t  frame_win = '0;
  int                win_fill = 0;
  logic [7:0]        sta_addr = DEF_STATION;
  logic [7:0]        rd_op = DEF_READ_OP;
  logic [7:0]        wr_op = DEF_WRITE_OP;

  mrfd_pkg::out_item_t  awaited_decodes [$];
  mrfd_pkg::out_item_t  head_decode;
  bit         quiet_run = 1'b0;
  int         mismatches = 0;
  int         bytes_sent = 0;
  int         bytes_framed = 0;
  int         decodes_checked = 0;
  int         settings_used = 1;
  int         status_seen [5] = '{default: 0};

  // Bitwise form of the reflected CRC: feed each data bit in at the low end.
  function automatic logic [15:0] frame_crc(input mrfd_pkg::frame_t f);
    logic [15:0] acc;
    logic        fb;
    acc = CRC_SEED;
    for (int n = 0; n < CRC_SPAN; n++) begin
      for (int b = 0; b < 8; b++) begin
        fb = acc[0] ^ f[n][b];
        acc = acc >> 1;
        if (fb) acc = acc ^ CRC_POLY_REFLECTED;
      end
    end
    return acc;
  endfunction

  function automatic bit map_read_address(input logic [15:0] a, output logic [5:0] kind,
                                          output logic [8:0] item);
    int hi;
    int lo;
    hi = a[15:8];
    lo = a[7:0];
    kind = K_NONE;
    item = '0;
    if (hi == 0) begin
      if (lo >= 'h01 && lo <= 'h03) begin kind = 6'(lo - 1); return 1'b1; end
      if (lo == 'h05) begin kind = 6'd3; return 1'b1; end
      if (lo == 'h10) begin kind = 6'd4; return 1'b1; end
      if (lo == 'h25) begin kind = 6'd5; return 1'b1; end
      if (lo >= 'h30 && lo <= 'h34) begin kind = 6'(6 + lo - 'h30); return 1'b1; end
      if (lo == 'h40) begin kind = 6'd11; return 1'b1; end
      if (lo == 'h50) begin kind = 6'd12; return 1'b1; end
      if (lo >= 'h60 && lo <= 'h69) begin kind = 6'(13 + lo - 'h60); return 1'b1; end
      if (lo >= 'h70 && lo <= 'h75) begin kind = 6'(23 + lo - 'h70); return 1'b1; end
    end
    if (hi > 15) return 1'b0;
    if (lo >= 'h11 && lo <= 'h24) begin
      kind = K_CELL_VOLT;
      item = 9'(hi * 20 + lo - 'h10);
      return 1'b1;
    end
    if (lo >= 'h26 && lo <= 'h2F) begin
      kind = K_TEMP;
      item = 9'(hi * 10 + lo - 'h25);
      return 1'b1;
    end
    if (lo >= 'h41 && lo <= 'h4A) begin
      kind = K_CELL_PAIR;
      item = 9'(hi * 20 + 2 * (lo - 'h40) - 1);
      return 1'b1;
    end
    if (lo >= 'h51 && lo <= 'h55) begin
      kind = K_TEMP_PAIR;
      item = 9'(hi * 10 + 2 * (lo - 'h50) - 1);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic step_frame_window(input mrfd_pkg::in_item_t it, output bit produced,
                                   output bit kept, output mrfd_pkg::out_item_t res);
    int         shift;
    logic [5:0] kind;
    logic [8:0] item;
    produced = 1'b0;
    kept = 1'b0;
    res = '0;
    // A full window slides to the earliest later station byte, or empties.
    if (win_fill == WINDOW_BYTES) begin
      shift = 0;
      for (int i = WINDOW_BYTES - 1; i >= 1; i--)
        if (frame_win[i] == sta_addr) shift = i;
      if (shift == 0) begin
        win_fill = 0;
      end else begin
        for (int j = 0; j + shift < WINDOW_BYTES; j++) frame_win[j] = frame_win[j + shift];
        win_fill = WINDOW_BYTES - shift;
      end
    end
    if (win_fill != 0 || it.rx_byte == sta_addr) begin
      frame_win[win_fill] = it.rx_byte;
      win_fill++;
      kept = 1'b1;
    end
    if (it.line_idle && win_fill == WINDOW_BYTES) begin
      win_fill = 0;
      produced = 1'b1;
      res.data_address = {frame_win[2], frame_win[3]};
      res.data_length = {frame_win[4], frame_win[5]};
      if (frame_crc(frame_win) != {frame_win[7], frame_win[6]}) begin
        res.status = mrfd_pkg::ST_CRC_ERR;
      end else if (frame_win[1] == rd_op) begin
        if (map_read_address(res.data_address, kind, item)) begin
          res.status = mrfd_pkg::ST_READ;
          res.request_kind = kind;
          res.item_index = item;
        end else begin
          res.status = mrfd_pkg::ST_BAD_ADDR;
        end
      end else if (frame_win[1] == wr_op) begin
        res.status = mrfd_pkg::ST_WRITE;
      end else begin
        res.status = mrfd_pkg::ST_UNKNOWN_CMD;
      end
    end
  endtask

  function automatic int pick_gap();
    int r;
    if (quiet_run) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_request(input mrfd_pkg::in_item_t it, input bit use_typed,
                              input mrfd_pkg::out_item_t typed_res);
    int                   gap;
    bit                   produced;
    bit                   kept;
    mrfd_pkg::out_item_t  res;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_payload <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    step_frame_window(it, produced, kept, res);
    bytes_sent++;
    if (kept) bytes_framed++;
    if (use_typed) awaited_decodes.push_back(typed_res);
    else if (produced) awaited_decodes.push_back(res);
  endtask

  // Sends the first cut bytes of a frame opened by the current station address.
  task automatic send_frame(input logic [7:0] cmd, input logic [15:0] addr, input logic [15:0] len,
                            input bit bad_crc, input int cut, input bit idle_end,
                            input bit idle_noise, input bit use_typed,
                            input mrfd_pkg::out_item_t typed_res);
    mrfd_pkg::frame_t    fr;
    logic [15:0]         crc;
    logic [7:0]          mask;
    mrfd_pkg::in_item_t  it;
    fr = '0;
    fr[0] = sta_addr;
    fr[1] = cmd;
    fr[2] = addr[15:8];
    fr[3] = addr[7:0];
    fr[4] = len[15:8];
    fr[5] = len[7:0];
    crc = frame_crc(fr);
    fr[6] = crc[7:0];
    fr[7] = crc[15:8];
    if (bad_crc) begin
      mask = 8'(1 << $urandom_range(0, 7));
      if ($urandom_range(0, 1) == 1) fr[7] = fr[7] ^ mask;
      else fr[6] = fr[6] ^ mask;
    end
    for (int i = 0; i < cut; i++) begin
      it.rx_byte = fr[i];
      it.line_idle = (i == cut - 1) ? idle_end : (idle_noise && $urandom_range(0, 9) == 0);
      send_request(it, use_typed && i == cut - 1, typed_res);
    end
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [7:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'($urandom), val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      mrfd_pkg::REG_STATION: sta_addr = val;
      mrfd_pkg::REG_READ_OP: rd_op = val;
      mrfd_pkg::REG_WRITE_OP: wr_op = val;
      default: ;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_for_quiet();
    in_valid <= 1'b0;
    while (awaited_decodes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Result side: random stall stretches, switched off during the quiet phase.
  initial begin
    int stall_len;
    wait (rst_n);
    forever begin
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      stall_len = pick_gap();
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_decodes.size() == 0) begin
        mismatches++;
        $display("%0t: decode with none expected: status %0d kind %0d item %0d addr %h len %h",
                 $time, out_payload.status, out_payload.request_kind, out_payload.item_index,
                 out_payload.data_address, out_payload.data_length);
      end else begin
        head_decode = awaited_decodes.pop_front();
        if (out_payload.status !== head_decode.status ||
            out_payload.request_kind !== head_decode.request_kind ||
            out_payload.item_index !== head_decode.item_index ||
            out_payload.data_address !== head_decode.data_address ||
            out_payload.data_length !== head_decode.data_length) begin
          mismatches++;
          $display("%0t: decode mismatch: expected status %0d kind %0d item %0d addr %h len %h,",
                   $time, head_decode.status, head_decode.request_kind,
                   head_decode.item_index, head_decode.data_address, head_decode.data_length);
          $display("    got status %0d kind %0d item %0d addr %h len %h",
                   out_payload.status, out_payload.request_kind, out_payload.item_index,
                   out_payload.data_address, out_payload.data_length);
        end
        decodes_checked++;
        status_seen[head_decode.status]++;
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("%0t: run did not complete, %0d decodes still awaited", $time,
             awaited_decodes.size());
    $display("modbus_request_frame_decoder_test failed");
    $finish;
  end

  initial begin
    int                   r;
    int                   n;
    int                   cut;
    int                   target;
    logic [7:0]           cmd;
    logic [7:0]           lo;
    logic [7:0]           p_sta;
    logic [7:0]           p_rd;
    logic [7:0]           p_wr;
    logic [15:0]          addr;
    mrfd_pkg::in_item_t   it;
    mrfd_pkg::out_item_t  typed;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    for (int row = 0; row < SCRIPT_ROWS; row++) begin
      if (SCRIPT[row].lead_on) begin
        it.rx_byte = SCRIPT[row].lead;
        it.line_idle = 1'b0;
        send_request(it, 1'b0, '0);
      end
      typed.status = SCRIPT[row].want_status;
      typed.request_kind = SCRIPT[row].want_kind;
      typed.item_index = SCRIPT[row].want_item;
      typed.data_address = SCRIPT[row].addr;
      typed.data_length = SCRIPT[row].len;
      send_frame(SCRIPT[row].cmd, SCRIPT[row].addr, SCRIPT[row].len, SCRIPT[row].bad_crc,
                 WINDOW_BYTES, SCRIPT[row].idle_end, 1'b0, SCRIPT[row].typed, typed);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      // The sender holds off here until every expected decode has been seen on the output.
      wait_for_quiet();
      case (ph)
        0: begin p_sta = DEF_STATION; p_rd = DEF_READ_OP; p_wr = DEF_WRITE_OP; end
        1: begin p_sta = 8'h00; p_rd = 8'h00; p_wr = 8'hFF; end
        2: begin p_sta = 8'hFF; p_rd = 8'hFF; p_wr = 8'h00; end
        3: begin p_sta = 8'h7E; p_rd = 8'h41; p_wr = 8'h41; end
        default: begin p_sta = 8'($urandom); p_rd = 8'($urandom); p_wr = 8'($urandom); end
      endcase
      write_register(mrfd_pkg::REG_STATION, p_sta);
      write_register(mrfd_pkg::REG_READ_OP, p_rd);
      write_register(mrfd_pkg::REG_WRITE_OP, p_wr);
      settings_used++;
      quiet_run = (ph == 3);
      target = bytes_framed + PHASE_BYTES;
      while (bytes_framed < target) begin
        n = $urandom_range(0, 9);
        if (n < 6) cmd = rd_op;
        else if (n < 8) cmd = wr_op;
        else cmd = 8'($urandom);
        case ($urandom_range(0, 4))
          0: addr = mrfd_pkg::FIXED_ADDR[$urandom_range(0, mrfd_pkg::FIXED_KINDS - 1)];
          1: begin
            case ($urandom_range(0, 3))
              0: lo = 8'($urandom_range('h11, 'h24));
              1: lo = 8'($urandom_range('h26, 'h2F));
              2: lo = 8'($urandom_range('h41, 'h4A));
              default: lo = 8'($urandom_range('h51, 'h55));
            endcase
            addr = {4'h0, 4'($urandom), lo};
          end
          2: addr = {8'($urandom_range(0, 17)), 8'($urandom)};
          default: addr = 16'($urandom);
        endcase
        r = $urandom_range(0, 99);
        if (r < 65) begin
          send_frame(cmd, addr, 16'($urandom), $urandom_range(0, 9) == 0, WINDOW_BYTES,
                     $urandom_range(0, 9) != 0, 1'b1, 1'b0, '0);
        end else if (r < 80) begin
          repeat ($urandom_range(1, 4)) begin
            it.rx_byte = 8'($urandom);
            it.line_idle = 1'($urandom_range(0, 1));
            send_request(it, 1'b0, '0);
          end
        end else if (r < 92) begin
          cut = $urandom_range(1, WINDOW_BYTES - 1);
          send_frame(cmd, addr, 16'($urandom), 1'b0, cut, 1'($urandom_range(0, 1)), 1'b1,
                     1'b0, '0);
        end else begin
          // Runs of station bytes keep the window sliding one byte at a time.
          repeat ($urandom_range(2, 10)) begin
            it.rx_byte = sta_addr;
            it.line_idle = 1'($urandom_range(0, 1));
            send_request(it, 1'b0, '0);
          end
        end
      end
    end
    quiet_run = 1'b0;
    wait_for_quiet();

    $display("Sent %0d bytes (%0d entered a frame window) under %0d register settings.",
             bytes_sent, bytes_framed, settings_used);
    $display("Checked %0d decodes: %0d read, %0d write, %0d CRC error, %0d unknown, %0d bad addr.",
             decodes_checked, status_seen[mrfd_pkg::ST_READ], status_seen[mrfd_pkg::ST_WRITE],
             status_seen[mrfd_pkg::ST_CRC_ERR], status_seen[mrfd_pkg::ST_UNKNOWN_CMD],
             status_seen[mrfd_pkg::ST_BAD_ADDR]);
    if (mismatches == 0) begin
      $display("modbus_request_frame_decoder_test passed");
    end else begin
      $display("modbus_request_frame_decoder_test failed");
    end
    $finish;
  end

endmodule
